@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/cpct_pkg.sv @@
`timescale 1ns / 1ps

package cpct_pkg;

    // Shape kinds of one collider.
    localparam logic KIND_RECT   = 1'b0;
    localparam logic KIND_CIRCLE = 1'b1;

    // Contact event codes.
    localparam int EV_BITS = 2;
    localparam logic [EV_BITS-1:0] EV_NONE  = 2'd0;
    localparam logic [EV_BITS-1:0] EV_ENTER = 2'd1;
    localparam logic [EV_BITS-1:0] EV_STAY  = 2'd2;
    localparam logic [EV_BITS-1:0] EV_EXIT  = 2'd3;

    // Four operands are squared on one shared multiplier.
    localparam int SEL_BITS  = 2;
    localparam int STEP_BITS = 3;
    localparam logic [STEP_BITS-1:0] STEP_LAST = 3'd4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                clr_en;
        logic                load;
        logic                prep;
        logic                sq_en;
        logic [SEL_BITS-1:0] sq_sel;
        logic                acc_lhs;
        logic                acc_rhs;
        logic                finish;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic rect_pair;
        logic out_free;
    } t_status;

endpackage

@@ rtl/cpct_pair_if.sv @@
`timescale 1ns / 1ps

interface cpct_pair_if #(
    parameter int ID_BITS    = 5,
    parameter int COORD_BITS = 20,
    parameter int SIZE_BITS  = 16
);
    logic                         valid;
    logic                         ready;
    logic [ID_BITS-1:0]           first_id;
    logic [ID_BITS-1:0]           second_id;
    logic                         first_kind;
    logic                         second_kind;
    logic signed [COORD_BITS-1:0] first_pos_x;
    logic signed [COORD_BITS-1:0] first_pos_y;
    logic signed [COORD_BITS-1:0] second_pos_x;
    logic signed [COORD_BITS-1:0] second_pos_y;
    logic [SIZE_BITS-1:0]         first_width;
    logic [SIZE_BITS-1:0]         first_height;
    logic [SIZE_BITS-1:0]         second_width;
    logic [SIZE_BITS-1:0]         second_height;

    modport source (
        output valid, first_id, second_id, first_kind, second_kind,
        output first_pos_x, first_pos_y, second_pos_x, second_pos_y,
        output first_width, first_height, second_width, second_height,
        input  ready
    );

    modport sink (
        input  valid, first_id, second_id, first_kind, second_kind,
        input  first_pos_x, first_pos_y, second_pos_x, second_pos_y,
        input  first_width, first_height, second_width, second_height,
        output ready
    );
endinterface

@@ rtl/cpct_result_if.sv @@
`timescale 1ns / 1ps

interface cpct_result_if;
    import cpct_pkg::*;

    logic               valid;
    logic               ready;
    logic [EV_BITS-1:0] contact_event;
    logic               overlapping;

    modport source (output valid, contact_event, overlapping, input ready);
    modport sink (input valid, contact_event, overlapping, output ready);
endinterface

@@ rtl/cpct_ctrl.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpct_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  cpct_pkg::t_status i_status,
    output cpct_pkg::t_cmd    o_cmd
);
    import cpct_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_PREP = 3'd2;
    localparam logic [2:0] ST_MUL  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [STEP_BITS-1:0] r_step;
    logic [STEP_BITS-1:0] n_step;

    // Commands decoded from the state and the multiply step.
    always_comb begin
        o_cmd         = '0;
        o_cmd.clr_en  = (r_state == ST_CLR);
        o_cmd.load    = (r_state == ST_IDLE) && i_in_valid;
        o_cmd.prep    = (r_state == ST_PREP);
        o_cmd.sq_en   = (r_state == ST_MUL) && (r_step != STEP_LAST);
        o_cmd.sq_sel  = r_step[SEL_BITS-1:0];
        o_cmd.acc_lhs = (r_state == ST_MUL) && (r_step inside {3'd1, 3'd2});
        o_cmd.acc_rhs = (r_state == ST_MUL) && (r_step inside {3'd3, 3'd4});
        o_cmd.finish  = (r_state == ST_DONE) && i_status.out_free;
    end

    assign o_in_ready = (r_state == ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            ST_CLR: begin
                if (i_status.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_step  = '0;
                n_state = i_status.rect_pair ? ST_DONE : ST_MUL;
            end
            ST_MUL: begin
                if (r_step == STEP_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLR;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `ASSERT_NEXT(a_one_item_at_a_time, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    `ASSERT_SAME(a_step_in_range, i_clk, i_rst_n, r_state == ST_MUL, r_step <= STEP_LAST)
    `ASSERT_NEXT(a_finish_returns_idle, i_clk, i_rst_n, o_cmd.finish, o_in_ready)

endmodule

@@ rtl/cpct_datapath.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cpct_datapath #(
    parameter int ID_BITS    = 5,
    parameter int COORD_BITS = 20,
    parameter int SIZE_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpct_pkg::t_cmd               i_cmd,
    output cpct_pkg::t_status            o_status,
    input  logic [ID_BITS-1:0]           i_first_id,
    input  logic [ID_BITS-1:0]           i_second_id,
    input  logic                         i_first_kind,
    input  logic                         i_second_kind,
    input  logic signed [COORD_BITS-1:0] i_first_pos_x,
    input  logic signed [COORD_BITS-1:0] i_first_pos_y,
    input  logic signed [COORD_BITS-1:0] i_second_pos_x,
    input  logic signed [COORD_BITS-1:0] i_second_pos_y,
    input  logic [SIZE_BITS-1:0]         i_first_width,
    input  logic [SIZE_BITS-1:0]         i_first_height,
    input  logic [SIZE_BITS-1:0]         i_second_width,
    input  logic [SIZE_BITS-1:0]         i_second_height,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [cpct_pkg::EV_BITS-1:0] o_contact_event,
    output logic                         o_overlapping
);
    import cpct_pkg::*;

    localparam int PAIR_BITS = 2 * ID_BITS;
    localparam int DEPTH     = 1 << PAIR_BITS;
    // Doubled coordinates plus sizes, and their differences, fit in WB signed bits.
    localparam int WB = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 3;
    localparam int PB = 2 * WB;

    // Captured item.
    logic                         r_a_circ;
    logic                         r_b_circ;
    logic [PAIR_BITS-1:0]         r_idx;
    logic signed [COORD_BITS-1:0] r_ax;
    logic signed [COORD_BITS-1:0] r_ay;
    logic signed [COORD_BITS-1:0] r_bx;
    logic signed [COORD_BITS-1:0] r_by;
    logic [SIZE_BITS-1:0]         r_aw;
    logic [SIZE_BITS-1:0]         r_ah;
    logic [SIZE_BITS-1:0]         r_bw;
    logic [SIZE_BITS-1:0]         r_bh;

    // Prepared operands and accumulators.
    logic signed [WB-1:0] r_op [4];
    logic                 r_rr_hit;
    logic                 r_old;
    logic [PB-1:0]        r_prod;
    logic [PB-1:0]        r_lhs;
    logic [PB-1:0]        r_rhs;

    // Contact bit store and its clearing counter.
    logic                 mem [DEPTH];
    logic [PAIR_BITS-1:0] r_clr_addr;

    // Output register.
    logic               r_out_valid;
    logic [EV_BITS-1:0] r_ev;
    logic               r_hit;

    logic signed [WB-1:0] ax2, ay2, bx2, by2, aw, ah, bw, bh;
    logic signed [WB-1:0] rdx, rdy, rabs_x, rabs_y;
    logic signed [WB-1:0] cx, cy, cw, ch, rx, ry, rw, rh;
    logic signed [WB-1:0] lo_x, hi_x, lo_y, hi_y, cl_x, cl_y;
    logic signed [WB-1:0] dx, dy, ra, rb;
    logic signed [WB-1:0] sq_op;
    logic signed [PB-1:0] sq;
    logic                 w_hit;
    logic [EV_BITS-1:0]   w_ev;
    logic                 w_ev_hit;

    // Doubled positions and unchanged sizes in the working width.
    assign ax2 = WB'(signed'({r_ax, 1'b0}));
    assign ay2 = WB'(signed'({r_ay, 1'b0}));
    assign bx2 = WB'(signed'({r_bx, 1'b0}));
    assign by2 = WB'(signed'({r_by, 1'b0}));
    assign aw  = WB'(signed'({1'b0, r_aw}));
    assign ah  = WB'(signed'({1'b0, r_ah}));
    assign bw  = WB'(signed'({1'b0, r_bw}));
    assign bh  = WB'(signed'({1'b0, r_bh}));

    // Box overlap test, strict on both axes.
    assign rdx    = ax2 - bx2;
    assign rdy    = ay2 - by2;
    assign rabs_x = (rdx < 0) ? -rdx : rdx;
    assign rabs_y = (rdy < 0) ? -rdy : rdy;

    // Circle against box: the circle side is picked, then clamped into the box.
    assign cx   = r_a_circ ? ax2 : bx2;
    assign cy   = r_a_circ ? ay2 : by2;
    assign cw   = r_a_circ ? aw : bw;
    assign ch   = r_a_circ ? ah : bh;
    assign rx   = r_a_circ ? bx2 : ax2;
    assign ry   = r_a_circ ? by2 : ay2;
    assign rw   = r_a_circ ? bw : aw;
    assign rh   = r_a_circ ? bh : ah;
    assign lo_x = rx - rw;
    assign hi_x = rx + rw;
    assign lo_y = ry - rh;
    assign hi_y = ry + rh;
    assign cl_x = (cx < lo_x) ? lo_x : ((cx > hi_x) ? hi_x : cx);
    assign cl_y = (cy < lo_y) ? lo_y : ((cy > hi_y) ? hi_y : cy);

    // Operand selection: distance terms, then radius terms.
    always_comb begin
        if (r_a_circ && r_b_circ) begin
            dx = (ax2 + aw) - (bx2 + bw);
            dy = (ay2 + ah) - (by2 + bh);
            ra = aw + bw;
            rb = '0;
        end else begin
            dx = cx - cl_x;
            dy = cy - cl_y;
            ra = cw;
            rb = ch;
        end
    end

    // Shared squaring unit.
    assign sq_op = r_op[i_cmd.sq_sel];
    assign sq    = sq_op * sq_op;

    // Overlap decision and contact event.
    assign w_hit = (!r_a_circ && !r_b_circ) ? r_rr_hit : (r_lhs <= r_rhs);

    always_comb begin
        if (w_hit) begin
            w_ev = r_old ? EV_STAY : EV_ENTER;
        end else begin
            w_ev = r_old ? EV_EXIT : EV_NONE;
        end
    end

    // Item capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_a_circ <= (i_first_kind == KIND_CIRCLE);
            r_b_circ <= (i_second_kind == KIND_CIRCLE);
            r_idx    <= {i_first_id, i_second_id};
            r_ax     <= i_first_pos_x;
            r_ay     <= i_first_pos_y;
            r_bx     <= i_second_pos_x;
            r_by     <= i_second_pos_y;
            r_aw     <= i_first_width;
            r_ah     <= i_first_height;
            r_bw     <= i_second_width;
            r_bh     <= i_second_height;
        end
    end

    // Operand preparation, squaring and accumulation.
    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_op[0]  <= dx;
            r_op[1]  <= dy;
            r_op[2]  <= ra;
            r_op[3]  <= rb;
            r_rr_hit <= (rabs_x < aw + bw) && (rabs_y < ah + bh);
            r_lhs    <= '0;
            r_rhs    <= '0;
        end else begin
            if (i_cmd.acc_lhs) begin
                r_lhs <= r_lhs + r_prod;
            end
            if (i_cmd.acc_rhs) begin
                r_rhs <= r_rhs + r_prod;
            end
        end
        if (i_cmd.sq_en) begin
            r_prod <= $unsigned(sq);
        end
    end

    // Contact store: clearing pass, read before the test, write at the end.
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.finish) begin
            mem[r_idx] <= w_hit;
        end
        if (i_cmd.prep) begin
            r_old <= mem[r_idx];
        end
    end

    // Clearing address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
        end else if (i_cmd.clr_en) begin
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    // Result register; a transfer on the output frees it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_ev  <= w_ev;
            r_hit <= w_hit;
        end
    end

    assign o_status.clr_last  = &r_clr_addr;
    assign o_status.rect_pair = !r_a_circ && !r_b_circ;
    assign o_status.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid     = r_out_valid;
    assign o_contact_event = r_ev;
    assign o_overlapping   = r_hit;

    // Enter and stay are the two events that report an overlap.
    assign w_ev_hit = (r_ev == EV_ENTER) || (r_ev == EV_STAY);

    `ASSERT_SAME(a_event_matches_hit, i_clk, i_rst_n, r_out_valid, r_hit == w_ev_hit)
    `ASSERT_NEXT(a_finish_loads_output, i_clk, i_rst_n, i_cmd.finish, r_out_valid)
    `ASSERT_NEXT(a_result_held_on_stall, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)

endmodule

@@ rtl/collider_pair_contact_tracker_unit.sv @@
`timescale 1ns / 1ps
// Channel    Dir  Modport  Transfer when        Payload
// i_pair     in   sink     valid && ready       ids, kinds, positions, sizes
// o_result   out  source   valid && ready       contact_event, overlapping
//
// A box pair goes through accept, prepare and finish; any pair with a circle
// also passes a multiply phase for the four squares that share one multiplier.
// After reset a clearing pass writes every contact bit, all 2**(2*ID_BITS)
// of them (1024 at the default), before the first pair is accepted.
// A new pair is accepted while the previous result still waits in the output
// register; a stalled output holds the finished pair until it is taken.

module collider_pair_contact_tracker_unit #(
    parameter int ID_BITS    = 5,
    parameter int COORD_BITS = 20,
    parameter int SIZE_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cpct_pair_if.sink     i_pair,
    cpct_result_if.source o_result
);
    import cpct_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready;

    assign i_pair.ready = in_ready;

    cpct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_pair.valid),
        .o_in_ready (in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    cpct_datapath #(
        .ID_BITS    (ID_BITS),
        .COORD_BITS (COORD_BITS),
        .SIZE_BITS  (SIZE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_first_id      (i_pair.first_id),
        .i_second_id     (i_pair.second_id),
        .i_first_kind    (i_pair.first_kind),
        .i_second_kind   (i_pair.second_kind),
        .i_first_pos_x   (i_pair.first_pos_x),
        .i_first_pos_y   (i_pair.first_pos_y),
        .i_second_pos_x  (i_pair.second_pos_x),
        .i_second_pos_y  (i_pair.second_pos_y),
        .i_first_width   (i_pair.first_width),
        .i_first_height  (i_pair.first_height),
        .i_second_width  (i_pair.second_width),
        .i_second_height (i_pair.second_height),
        .i_out_ready     (o_result.ready),
        .o_out_valid     (o_result.valid),
        .o_contact_event (o_result.contact_event),
        .o_overlapping   (o_result.overlapping)
    );

endmodule
